[rtl/c2f_pkg.sv]
package c2f_pkg;

    // Shared square-root / divide unit
    typedef enum logic {
        SQ_OP_SQRT = 1'b0,
        SQ_OP_DIV  = 1'b1
    } sq_op_t;

    typedef struct packed {
        logic       start;
        sq_op_t     op;
        logic [6:0] steps;
    } sq_req_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WAYPOINT_COUNT = 2'd0,
        CFG_CENTER_X       = 2'd1,
        CFG_CENTER_Y       = 2'd2
    } cfg_index_t;

    localparam logic [31:0] CENTER_X_RESET = 32'd256000;
    localparam logic [31:0] CENTER_Y_RESET = 32'd512000;

    localparam logic [32:0] NEAR_LIMIT     = 33'd25600000;
    localparam logic [50:0] NEAR_LIMIT_SQ  = 51'd655360000000000;
    localparam logic [21:0] QUARTER_PI_Q16 = 22'd51472;
    localparam logic [19:0] HALF_PI_Q16    = 20'd102944;
    localparam logic [4:0]  CORDIC_LAST    = 5'd16;
    localparam logic [30:0] S_MAX          = 31'h7FFF_FFFF;

    localparam logic [6:0] SQRT_STEPS_SHORT = 7'd33;
    localparam logic [6:0] SQRT_STEPS_LONG  = 7'd64;
    localparam logic [6:0] DIV_STEPS        = 7'd40;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] a;
        unique case (i)
            5'd0:    a = 17'd51472;
            5'd1:    a = 17'd30386;
            5'd2:    a = 17'd16055;
            5'd3:    a = 17'd8150;
            5'd4:    a = 17'd4091;
            5'd5:    a = 17'd2047;
            5'd6:    a = 17'd1024;
            5'd7:    a = 17'd512;
            5'd8:    a = 17'd256;
            5'd9:    a = 17'd128;
            5'd10:   a = 17'd64;
            5'd11:   a = 17'd32;
            5'd12:   a = 17'd16;
            5'd13:   a = 17'd8;
            5'd14:   a = 17'd4;
            5'd15:   a = 17'd2;
            5'd16:   a = 17'd1;
            default: a = 17'd0;
        endcase
        return a;
    endfunction

endpackage

[rtl/c2f_ram.sv]
module c2f_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/c2f_sqdiv.sv]
module c2f_sqdiv
    import c2f_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  sq_req_t       req,
    input  logic [127:0]  num,
    input  logic [55:0]   rem_init,
    input  logic [63:0]   den,
    output logic          done,
    output logic [63:0]   result
);

    logic [67:0]  rem_reg, rem_next;
    logic [127:0] num_reg, num_next;
    logic [63:0]  root_reg, root_next;
    logic [63:0]  den_reg, den_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    sq_op_t       op_reg, op_next;

    logic [67:0] rem_sh;
    logic [67:0] trial;
    logic [68:0] diff;
    logic        ge;

    always_comb
    begin
        // sqrt brings down two bits against 4*root+1, divide one bit against the divisor
        if (op_reg == SQ_OP_SQRT)
        begin
            rem_sh = {rem_reg[65:0], num_reg[127:126]};
            trial  = {2'b00, root_reg, 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[66:0], num_reg[127]};
            trial  = {4'b0000, den_reg};
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = !diff[68];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        root_next = root_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {12'b0, rem_init};
            num_next  = num;
            root_next = '0;
            den_next  = den;
            cnt_next  = req.steps;
            op_next   = req.op;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[67:0] : rem_sh;
            root_next = {root_reg[62:0], ge};
            num_next  = (op_reg == SQ_OP_SQRT) ? {num_reg[125:0], 2'b00}
                                               : {num_reg[126:0], 1'b0};
            cnt_next  = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= SQ_OP_SQRT;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        root_reg <= root_next;
        den_reg  <= den_next;
    end

    assign done   = done_reg;
    assign result = root_reg;

endmodule

[rtl/cartesian_to_frenet.sv]
// Cartesian to Frenet converter over a closed waypoint track.
// Input channel (in_valid/in_ready): mode 0 writes one waypoint into the table
// at waypoint_index and gives no result; mode 1 runs a query on pos_x, pos_y,
// heading and gives one word on the output channel (frenet_s, frenet_d, status).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 waypoint count,
// 1 centre x, 2 centre y; other indexes are dropped. Write config only when idle.
// A query with N active waypoints whose previous waypoint index is P scans all
// N waypoints on the one shared multiplier, each of the P segment lengths
// needs a 33-step square root, and the end runs a 64-step root and two
// 40-step divides in the shared root/divide unit, or one 33-step root if the
// last segment has zero length. An empty table answers with status 1.
// in_ready is low while a query runs.
// The result sits in an output register; the next item is accepted while it
// waits, and a query that finishes while the receiver stalls holds until the
// register frees. Reset clears the count and restores the default centre; the
// table contents are undefined until written.
module cartesian_to_frenet
    import c2f_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [7:0]         waypoint_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        frenet_s,
    output logic signed [31:0] frenet_d,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    typedef enum logic [24:0] {
        ST_IDLE    = 25'h0000001,
        ST_START   = 25'h0000002,
        ST_SC_RD   = 25'h0000004,
        ST_SC_DAT  = 25'h0000008,
        ST_SC_M2   = 25'h0000010,
        ST_SC_M3   = 25'h0000020,
        ST_BR_RD   = 25'h0000040,
        ST_BR_DAT  = 25'h0000080,
        ST_CORD    = 25'h0000100,
        ST_BR_CMP  = 25'h0000200,
        ST_SG_RD   = 25'h0000400,
        ST_SG_DAT  = 25'h0000800,
        ST_SG_M2   = 25'h0001000,
        ST_SG_M3   = 25'h0002000,
        ST_SG_SQ   = 25'h0004000,
        ST_SG_NEXT = 25'h0008000,
        ST_NX_RD   = 25'h0010000,
        ST_NX_DAT  = 25'h0020000,
        ST_PROD    = 25'h0040000,
        ST_CHOOSE  = 25'h0080000,
        ST_Z_SQ    = 25'h0100000,
        ST_S_SQ    = 25'h0200000,
        ST_DIV_P   = 25'h0400000,
        ST_DIV_D   = 25'h0800000,
        ST_OUT     = 25'h1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [8:0]  wcount_reg;
    logic [31:0] cen_x_reg, cen_y_reg;

    // query
    logic [31:0] q_x_reg, q_y_reg;
    logic [15:0] head_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] idx_reg, best_reg, next_reg, prev_reg;
    logic [50:0] bestsq_reg;
    logic [32:0] dx_reg, dy_reg;
    logic [65:0] acc_reg;
    logic [31:0] last_x_reg, last_y_reg;
    logic [35:0] cd_x_reg, cd_y_reg;
    logic [19:0] cd_z_reg;
    logic [4:0]  it_reg;
    logic [32:0] nx_reg, ny_reg, xx_reg, xy_reg, cx_reg, cy_reg, ex_reg, ey_reg;
    logic [3:0]  pk_reg;
    logic [65:0] sum_reg [7];
    logic [63:0] s_norm_reg;
    logic [41:0] ssum_reg;
    logic [39:0] proj_reg, dmag_reg;
    logic        neg_reg, stat_reg;

    // shared multiplier
    logic [32:0] mul_a, mul_b;
    logic        mul_n;
    logic [32:0] mag_a, mag_b;
    logic [63:0] mag_reg;
    logic        mneg_reg;
    logic [65:0] prod_val;

    // output
    logic        out_valid_reg, out_valid_next;
    logic [30:0] os_reg;
    logic [31:0] od_reg;
    logic        ost_reg;

    // memories
    logic          ram_we;
    logic [31:0]   wa_wide;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   rd_x, rd_y;

    // root / divide unit
    sq_req_t     sq_req;
    logic [127:0] sq_num;
    logic [55:0] sq_rem0;
    logic [63:0] sq_den;
    logic        sq_done;
    logic [63:0] sq_result;

    logic in_acc, out_acc, cfg_acc;

    // helpers
    logic [31:0]   cnt_wide;
    logic [CW-1:0] cnt_calc;
    logic          idx_last_scan, idx_is_prev;
    logic [32:0]   scan_dx, scan_dy, seg_dx, seg_dy;
    logic [65:0]   pair_sum;
    logic          far;
    logic [32:0]   adx, ady;
    logic [35:0]   xs, ys;
    logic [21:0]   hdiff, ahdiff;
    logic [CW-1:0] nxt_c, nxt_a, prv_c;
    logic [65:0]   dot_v, cr_v, cc_v;
    logic [64:0]   dot_m, cr_m, cc_m;
    logic          neg_calc;
    logic [42:0]   s_tot;
    logic [32:0]   d_m;
    logic [2:0]    sum_idx;
    logic [3:0]    pk_m1;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid_reg && out_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // waypoint writes
    assign wa_wide   = 32'(waypoint_index);
    assign ram_we    = in_acc && !mode && (wa_wide < 32'(MAX_WAYPOINTS));
    assign ram_waddr = wa_wide[AW-1:0];

    always_comb
    begin
        if (state_reg == ST_BR_RD)
        begin
            ram_raddr = best_reg;
        end
        else if (state_reg == ST_NX_RD)
        begin
            ram_raddr = next_reg;
        end
        else
        begin
            ram_raddr = idx_reg;
        end
    end

    c2f_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pos_x),
        .raddr (ram_raddr),
        .rdata (rd_x)
    );

    c2f_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pos_y),
        .raddr (ram_raddr),
        .rdata (rd_y)
    );

    c2f_sqdiv u_sqdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (sq_req),
        .num      (sq_num),
        .rem_init (sq_rem0),
        .den      (sq_den),
        .done     (sq_done),
        .result   (sq_result)
    );

    // clamp count to table depth
    assign cnt_wide = (32'(wcount_reg) > 32'(MAX_WAYPOINTS)) ? 32'(MAX_WAYPOINTS)
                                                               : 32'(wcount_reg);
    assign cnt_calc = cnt_wide[CW-1:0];

    assign idx_last_scan = (CW'(idx_reg) == (cnt_reg - CW'(1)));
    assign idx_is_prev   = (idx_reg == prev_reg);

    assign scan_dx = {rd_x[31], rd_x} - {q_x_reg[31], q_x_reg};
    assign scan_dy = {rd_y[31], rd_y} - {q_y_reg[31], q_y_reg};
    assign seg_dx  = {rd_x[31], rd_x} - {last_x_reg[31], last_x_reg};
    assign seg_dy  = {rd_y[31], rd_y} - {last_y_reg[31], last_y_reg};

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_n = 1'b0;
        unique case (state_reg)
            ST_SC_DAT:
            begin
                mul_a = scan_dx;
                mul_b = scan_dx;
            end
            ST_SG_DAT:
            begin
                mul_a = seg_dx;
                mul_b = seg_dx;
            end
            ST_SC_M2, ST_SG_M2:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            ST_PROD:
            begin
                unique case (pk_reg)
                    4'd0:  begin mul_a = nx_reg; mul_b = nx_reg; end
                    4'd1:  begin mul_a = ny_reg; mul_b = ny_reg; end
                    4'd2:  begin mul_a = xx_reg; mul_b = nx_reg; end
                    4'd3:  begin mul_a = xy_reg; mul_b = ny_reg; end
                    4'd4:  begin mul_a = nx_reg; mul_b = xy_reg; end
                    4'd5:  begin mul_a = ny_reg; mul_b = xx_reg; mul_n = 1'b1; end
                    4'd6:  begin mul_a = nx_reg; mul_b = cy_reg; end
                    4'd7:  begin mul_a = ny_reg; mul_b = cx_reg; mul_n = 1'b1; end
                    4'd8:  begin mul_a = xx_reg; mul_b = xx_reg; end
                    4'd9:  begin mul_a = xy_reg; mul_b = xy_reg; end
                    4'd10: begin mul_a = ex_reg; mul_b = ex_reg; end
                    4'd11: begin mul_a = ey_reg; mul_b = ey_reg; end
                    4'd12: begin mul_a = cx_reg; mul_b = cx_reg; end
                    4'd13: begin mul_a = cy_reg; mul_b = cy_reg; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mag_a    = mul_a[32] ? (33'd0 - mul_a) : mul_a;
    assign mag_b    = mul_b[32] ? (33'd0 - mul_b) : mul_b;
    assign prod_val = mneg_reg ? (66'd0 - {2'b00, mag_reg}) : {2'b00, mag_reg};
    assign pair_sum = acc_reg + prod_val;

    assign adx = dx_reg[32] ? (33'd0 - dx_reg) : dx_reg;
    assign ady = dy_reg[32] ? (33'd0 - dy_reg) : dy_reg;
    assign far = (adx >= NEAR_LIMIT) || (ady >= NEAR_LIMIT);

    // CORDIC step
    assign xs = $signed(cd_x_reg) >>> it_reg;
    assign ys = $signed(cd_y_reg) >>> it_reg;

    // heading test and neighbor selection
    assign hdiff  = {{2{head_reg[15]}}, head_reg, 4'b0000} - {{2{cd_z_reg[19]}}, cd_z_reg};
    assign ahdiff = hdiff[21] ? (22'd0 - hdiff) : hdiff;
    assign nxt_c  = CW'(best_reg) + ((ahdiff > QUARTER_PI_Q16) ? CW'(1) : CW'(0));
    assign nxt_a  = (nxt_c >= cnt_reg) ? CW'(0) : nxt_c;
    assign prv_c  = (nxt_a == CW'(0)) ? (cnt_reg - CW'(1)) : (nxt_a - CW'(1));

    assign pk_m1   = pk_reg - 4'd1;
    assign sum_idx = pk_m1[3:1];

    // projection and offset magnitudes
    assign dot_v = sum_reg[1];
    assign cr_v  = sum_reg[2];
    assign cc_v  = sum_reg[3];
    assign dot_m = dot_v[65] ? 65'(66'd0 - dot_v) : dot_v[64:0];
    assign cr_m  = cr_v[65] ? 65'(66'd0 - cr_v) : cr_v[64:0];
    assign cc_m  = cc_v[65] ? 65'(66'd0 - cc_v) : cc_v[64:0];
    assign neg_calc = (cr_m == '0) ||
                      ((cr_v[65] == cc_v[65]) && (cc_m != '0) &&
                       ({1'b0, cr_m} <= {cc_m, 1'b0}));

    // unit requests
    always_comb
    begin
        sq_req   = '{start: 1'b0, op: SQ_OP_SQRT, steps: 7'd0};
        sq_num   = '0;
        sq_rem0  = '0;
        sq_den   = s_norm_reg;
        unique case (state_reg)
            ST_SG_M3:
            begin
                sq_req = '{start: 1'b1, op: SQ_OP_SQRT, steps: SQRT_STEPS_SHORT};
                sq_num = {1'b0, pair_sum[64:0], 62'b0};
            end
            ST_CHOOSE:
            begin
                if (sum_reg[0] == '0)
                begin
                    sq_req = '{start: 1'b1, op: SQ_OP_SQRT, steps: SQRT_STEPS_SHORT};
                    sq_num = {1'b0, sum_reg[4][64:0], 62'b0};
                end
                else
                begin
                    sq_req = '{start: 1'b1, op: SQ_OP_SQRT, steps: SQRT_STEPS_LONG};
                    sq_num = {1'b0, sum_reg[0][64:0], 62'b0};
                end
            end
            ST_S_SQ:
            begin
                // divide |dot| * 2^31 by the scaled norm
                sq_req  = '{start: sq_done, op: SQ_OP_DIV, steps: DIV_STEPS};
                sq_rem0 = dot_m[64:9];
                sq_num  = {dot_m[8:0], 119'b0};
                sq_den  = sq_result;
            end
            ST_DIV_P:
            begin
                sq_req  = '{start: sq_done, op: SQ_OP_DIV, steps: DIV_STEPS};
                sq_rem0 = cr_m[64:9];
                sq_num  = {cr_m[8:0], 119'b0};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_acc && mode) state_next = ST_START;
            ST_START:   state_next = (cnt_calc == '0) ? ST_OUT : ST_SC_RD;
            ST_SC_RD:   state_next = ST_SC_DAT;
            ST_SC_DAT:  state_next = ST_SC_M2;
            ST_SC_M2:   state_next = ST_SC_M3;
            ST_SC_M3:   state_next = idx_last_scan ? ST_BR_RD : ST_SC_RD;
            ST_BR_RD:   state_next = ST_BR_DAT;
            ST_BR_DAT:
            begin
                if ((scan_dx == '0) && (scan_dy == '0))
                begin
                    state_next = ST_BR_CMP;
                end
                else
                begin
                    state_next = ST_CORD;
                end
            end
            ST_CORD:    if (it_reg == CORDIC_LAST) state_next = ST_BR_CMP;
            ST_BR_CMP:  state_next = ST_SG_RD;
            ST_SG_RD:   state_next = ST_SG_DAT;
            ST_SG_DAT:  state_next = (idx_reg == '0) ? ST_SG_NEXT : ST_SG_M2;
            ST_SG_M2:   state_next = ST_SG_M3;
            ST_SG_M3:   state_next = ST_SG_SQ;
            ST_SG_SQ:   if (sq_done) state_next = ST_SG_NEXT;
            ST_SG_NEXT: state_next = idx_is_prev ? ST_NX_RD : ST_SG_RD;
            ST_NX_RD:   state_next = ST_NX_DAT;
            ST_NX_DAT:  state_next = ST_PROD;
            ST_PROD:    if (pk_reg == 4'd14) state_next = ST_CHOOSE;
            ST_CHOOSE:  state_next = (sum_reg[0] == '0) ? ST_Z_SQ : ST_S_SQ;
            ST_Z_SQ:    if (sq_done) state_next = ST_OUT;
            ST_S_SQ:    if (sq_done) state_next = ST_DIV_P;
            ST_DIV_P:   if (sq_done) state_next = ST_DIV_D;
            ST_DIV_D:   if (sq_done) state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_OUT) && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
    end

    // result saturation
    assign s_tot = 43'(ssum_reg) + 43'(proj_reg);
    assign d_m   = (40'(dmag_reg) > 40'h0080000000) ? 33'h080000000 : dmag_reg[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wcount_reg    <= '0;
            cen_x_reg     <= CENTER_X_RESET;
            cen_y_reg     <= CENTER_Y_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    CFG_WAYPOINT_COUNT: wcount_reg <= cfg_data[8:0];
                    CFG_CENTER_X:       cen_x_reg  <= cfg_data;
                    CFG_CENTER_Y:       cen_y_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_a[31:0] * mag_b[31:0];
        mneg_reg <= mul_a[32] ^ mul_b[32] ^ mul_n;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    q_x_reg  <= pos_x;
                    q_y_reg  <= pos_y;
                    head_reg <= heading;
                end
            end
            ST_START:
            begin
                cnt_reg    <= cnt_calc;
                idx_reg    <= '0;
                best_reg   <= '0;
                bestsq_reg <= NEAR_LIMIT_SQ;
                ssum_reg   <= '0;
                proj_reg   <= '0;
                dmag_reg   <= '0;
                neg_reg    <= 1'b0;
                stat_reg   <= (cnt_calc == '0);
            end
            ST_SC_DAT:
            begin
                dx_reg <= scan_dx;
                dy_reg <= scan_dy;
            end
            ST_SC_M2:
            begin
                acc_reg <= prod_val;
            end
            ST_SC_M3:
            begin
                // keep the first index on ties
                if (!far && (pair_sum < 66'(bestsq_reg)))
                begin
                    bestsq_reg <= pair_sum[50:0];
                    best_reg   <= idx_reg;
                end
                idx_reg <= idx_reg + AW'(1);
            end
            ST_BR_DAT:
            begin
                it_reg <= '0;
                if ((scan_dx == '0) && (scan_dy == '0))
                begin
                    cd_z_reg <= '0;
                end
                else if (scan_dx[32] && !scan_dy[32])
                begin
                    cd_x_reg <= {{3{scan_dy[32]}}, scan_dy};
                    cd_y_reg <= 36'd0 - {{3{scan_dx[32]}}, scan_dx};
                    cd_z_reg <= HALF_PI_Q16;
                end
                else if (scan_dx[32])
                begin
                    cd_x_reg <= 36'd0 - {{3{scan_dy[32]}}, scan_dy};
                    cd_y_reg <= {{3{scan_dx[32]}}, scan_dx};
                    cd_z_reg <= 20'd0 - HALF_PI_Q16;
                end
                else
                begin
                    cd_x_reg <= {{3{scan_dx[32]}}, scan_dx};
                    cd_y_reg <= {{3{scan_dy[32]}}, scan_dy};
                    cd_z_reg <= '0;
                end
            end
            ST_CORD:
            begin
                if (!cd_y_reg[35] && (cd_y_reg != '0))
                begin
                    cd_x_reg <= cd_x_reg + ys;
                    cd_y_reg <= cd_y_reg - xs;
                    cd_z_reg <= cd_z_reg + {3'b000, atan_q16(it_reg)};
                end
                else
                begin
                    cd_x_reg <= cd_x_reg - ys;
                    cd_y_reg <= cd_y_reg + xs;
                    cd_z_reg <= cd_z_reg - {3'b000, atan_q16(it_reg)};
                end
                it_reg <= it_reg + 5'd1;
            end
            ST_BR_CMP:
            begin
                next_reg <= nxt_a[AW-1:0];
                prev_reg <= prv_c[AW-1:0];
                idx_reg  <= '0;
            end
            ST_SG_DAT:
            begin
                dy_reg     <= seg_dy;
                last_x_reg <= rd_x;
                last_y_reg <= rd_y;
            end
            ST_SG_M2:
            begin
                acc_reg <= prod_val;
            end
            ST_SG_SQ:
            begin
                if (sq_done)
                begin
                    ssum_reg <= ssum_reg + 42'(sq_result[32:0]);
                end
            end
            ST_SG_NEXT:
            begin
                if (!idx_is_prev)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            ST_NX_DAT:
            begin
                // last point holds the previous waypoint here
                nx_reg <= seg_dx;
                ny_reg <= seg_dy;
                xx_reg <= {q_x_reg[31], q_x_reg} - {last_x_reg[31], last_x_reg};
                xy_reg <= {q_y_reg[31], q_y_reg} - {last_y_reg[31], last_y_reg};
                cx_reg <= {cen_x_reg[31], cen_x_reg} - {last_x_reg[31], last_x_reg};
                cy_reg <= {cen_y_reg[31], cen_y_reg} - {last_y_reg[31], last_y_reg};
                ex_reg <= {cen_x_reg[31], cen_x_reg} - {q_x_reg[31], q_x_reg};
                ey_reg <= {cen_y_reg[31], cen_y_reg} - {q_y_reg[31], q_y_reg};
                pk_reg <= '0;
            end
            ST_PROD:
            begin
                if (pk_reg != 4'd0)
                begin
                    if (!pk_m1[0])
                    begin
                        acc_reg <= prod_val;
                    end
                    else
                    begin
                        sum_reg[sum_idx] <= pair_sum;
                    end
                end
                pk_reg <= pk_reg + 4'd1;
            end
            ST_Z_SQ:
            begin
                if (sq_done)
                begin
                    dmag_reg <= sq_result[39:0];
                    proj_reg <= '0;
                    neg_reg  <= (sum_reg[5] <= sum_reg[6]);
                end
            end
            ST_S_SQ:
            begin
                if (sq_done)
                begin
                    s_norm_reg <= sq_result;
                end
            end
            ST_DIV_P:
            begin
                if (sq_done)
                begin
                    proj_reg <= sq_result[39:0];
                end
            end
            ST_DIV_D:
            begin
                if (sq_done)
                begin
                    dmag_reg <= sq_result[39:0];
                    neg_reg  <= neg_calc;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    os_reg  <= (s_tot > 43'(S_MAX)) ? S_MAX : s_tot[30:0];
                    od_reg  <= neg_reg ? 32'(33'd0 - d_m)
                                       : ((d_m > 33'h07FFFFFFF) ? 32'h7FFFFFFF : d_m[31:0]);
                    ost_reg <= stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign frenet_s  = os_reg;
    assign frenet_d  = od_reg;
    assign status    = ost_reg;

endmodule
